// ===== src/mrp_pkg.sv =====
package mrp_pkg;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_WORD32  = 3'd1;
    localparam logic [2:0] KIND_JUMP26  = 3'd2;
    localparam logic [2:0] KIND_HI16    = 3'd3;
    localparam logic [2:0] KIND_LO16    = 3'd4;
    localparam logic [2:0] KIND_WORD64  = 3'd5;
    localparam logic [2:0] KIND_HIGHER  = 3'd6;
    localparam logic [2:0] KIND_HIGHEST = 3'd7;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_WEAK_SKIP   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN     = 3'd2;
    localparam logic [2:0] ST_MISALIGNED  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW    = 3'd4;
    localparam logic [2:0] ST_MISMATCH    = 3'd5;
    localparam logic [2:0] ST_STORE_FULL  = 3'd6;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd7;

    localparam logic [63:0] HI16_ROUND    = 64'h0000_0000_0000_8000;
    localparam logic [63:0] HIGHER_ROUND  = 64'h0000_0000_8000_8000;
    localparam logic [63:0] HIGHEST_ROUND = 64'h0000_8000_8000_8000;
    localparam logic [31:0] LO_ROUND      = 32'h0000_8000;
    localparam logic [25:0] JUMP_MASK     = 26'h3ff_ffff;

    typedef struct packed {
        logic [63:0] addr;
        logic [63:0] value;
        logic        wide;
        logic        we;
        logic [2:0]  status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] word;
        logic [63:0] value;
    } pend_entry_t;

endpackage

// ===== src/mrp_in_if.sv =====
interface mrp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  rel_kind;
    logic        explicit_addend;
    logic [63:0] symbol_value;
    logic signed [63:0] addend;
    logic        symbol_unresolved;
    logic        symbol_weak;
    logic [63:0] site_address;
    logic [31:0] site_word;

    modport source (
        output valid, rel_kind, explicit_addend, symbol_value, addend,
               symbol_unresolved, symbol_weak, site_address, site_word,
        input  ready
    );
    modport sink (
        input  valid, rel_kind, explicit_addend, symbol_value, addend,
               symbol_unresolved, symbol_weak, site_address, site_word,
        output ready
    );
endinterface

// ===== src/mrp_out_if.sv =====
interface mrp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] patch_address;
    logic [63:0] patch_value;
    logic        patch_wide;
    logic        write_enable;
    logic [2:0]  status;
    logic        last;

    modport source (
        output valid, patch_address, patch_value, patch_wide, write_enable,
               status, last,
        input  ready
    );
    modport sink (
        input  valid, patch_address, patch_value, patch_wide, write_enable,
               status, last,
        output ready
    );
endinterface

// ===== src/mrp_ram.sv =====
module mrp_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/mrp_patch.sv =====
module mrp_patch
    import mrp_pkg::*;
(
    input  logic [2:0]  rel_kind,
    input  logic        explicit_addend,
    input  logic        symbol_unresolved,
    input  logic        symbol_weak,
    input  logic [63:0] site_address,
    input  logic [31:0] site_word,
    input  logic [63:0] value,
    input  logic        store_full,
    output result_t     res,
    output logic        push,
    output logic        drain,
    output logic [31:0] lo_round_sum,
    output logic [31:0] lo_word
);
    logic [63:0] round_k;
    logic [63:0] rounded;
    logic [31:0] lo_ext;
    logic [31:0] site_next;
    logic [25:0] jump_field;

    always_comb
    begin
        lo_ext       = {{16{site_word[15]}}, site_word[15:0]};
        // V + lo + 0x8000; the low half of V + lo is that with bit 15 flipped
        lo_round_sum = value[31:0] + lo_ext + LO_ROUND;
        lo_word      = {site_word[31:16], lo_round_sum[15:0] ^ 16'h8000};
        site_next    = site_address[31:0] + 32'd4;
        jump_field   = explicit_addend ? value[27:2]
                                       : (site_word[25:0] + value[27:2]) & JUMP_MASK;

        case (rel_kind)
            KIND_HIGHER:  round_k = HIGHER_ROUND;
            KIND_HIGHEST: round_k = HIGHEST_ROUND;
            default:      round_k = HI16_ROUND;
        endcase
        rounded = value + round_k;

        res        = '0;
        res.last   = 1'b1;
        push       = 1'b0;
        drain      = 1'b0;

        if (symbol_unresolved)
        begin
            res.status = symbol_weak ? ST_WEAK_SKIP : ST_UNKNOWN;
        end
        else
        begin
            unique case (rel_kind)
                KIND_NONE:
                begin
                    res.status = ST_OK;
                end
                KIND_WORD32:
                begin
                    res.we    = 1'b1;
                    res.addr  = site_address;
                    res.value = {32'd0, explicit_addend ? value[31:0]
                                                        : site_word + value[31:0]};
                end
                KIND_JUMP26:
                begin
                    if (value[1:0] != 2'd0)
                    begin
                        res.status = ST_MISALIGNED;
                    end
                    else if (value[31:28] != site_next[31:28])
                    begin
                        res.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        res.we    = 1'b1;
                        res.addr  = site_address;
                        res.value = {32'd0, site_word[31:26], jump_field};
                    end
                end
                KIND_HI16:
                begin
                    if (explicit_addend)
                    begin
                        res.we    = 1'b1;
                        res.addr  = site_address;
                        res.value = {32'd0, site_word[31:16], rounded[31:16]};
                    end
                    else if (store_full)
                    begin
                        res.status = ST_STORE_FULL;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                KIND_LO16:
                begin
                    if (explicit_addend)
                    begin
                        res.we    = 1'b1;
                        res.addr  = site_address;
                        res.value = {32'd0, site_word[31:16], value[15:0]};
                    end
                    else
                    begin
                        drain = 1'b1;
                    end
                end
                KIND_WORD64:
                begin
                    if (explicit_addend)
                    begin
                        res.we    = 1'b1;
                        res.wide  = 1'b1;
                        res.addr  = site_address;
                        res.value = value;
                    end
                    else
                    begin
                        res.status = ST_UNSUPPORTED;
                    end
                end
                KIND_HIGHER:
                begin
                    if (explicit_addend)
                    begin
                        res.we    = 1'b1;
                        res.addr  = site_address;
                        res.value = {32'd0, site_word[31:16], rounded[47:32]};
                    end
                    else
                    begin
                        res.status = ST_UNSUPPORTED;
                    end
                end
                KIND_HIGHEST:
                begin
                    if (explicit_addend)
                    begin
                        res.we    = 1'b1;
                        res.addr  = site_address;
                        res.value = {32'd0, site_word[31:16], rounded[63:48]};
                    end
                    else
                    begin
                        res.status = ST_UNSUPPORTED;
                    end
                end
                default:
                begin
                    res.status = ST_UNSUPPORTED;
                end
            endcase
        end
    end
endmodule

// ===== src/mips_relocation_patcher.sv =====
// Channel  Dir  Beat contents
// -------  ---  ----------------------------------------------------------
// rel      in   one relocation: kind, form, symbol, addend, site, site word
// patch    out  one result: address, value, wide, write enable, status, last
//
// Flow: an item is taken in S_IDLE, its effective value is formed in S_VALUE
// and its result is loaded into the output register in S_PATCH. A REL LO16
// then walks the stored HI16 entries, newest first: S_READ reads an entry
// from the pending store and S_ENTRY checks and patches it; S_FINAL then
// patches the LO16 itself.
// Reset clears the state machine, the pending count and the output valid; the
// pending store itself is not cleared, the count marks the live entries.
// A stall on patch holds the block only when a new result must be loaded; the
// next item is taken while the last result still waits in the output register.
module mips_relocation_patcher
    import mrp_pkg::*;
#(
    parameter int PENDING_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mrp_in_if.sink    rel,
    mrp_out_if.source patch
);
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int ENT_W = $bits(pend_entry_t);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_VALUE = 6'b000010,
        S_PATCH = 6'b000100,
        S_READ  = 6'b001000,
        S_ENTRY = 6'b010000,
        S_FINAL = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    // captured item
    logic [2:0]  kind_reg;
    logic        rela_reg;
    logic [63:0] sym_reg;
    logic [63:0] addend_reg;
    logic        unres_reg;
    logic        weak_reg;
    logic [63:0] site_reg;
    logic [31:0] word_reg;
    logic [63:0] v_reg;

    result_t     item_res;
    logic        item_push;
    logic        item_drain;
    logic [31:0] lo_round_sum;
    logic [31:0] lo_word;
    logic        store_full;

    logic        ram_we;
    pend_entry_t wr_entry;
    pend_entry_t rd_entry;
    logic [ENT_W-1:0] rd_bits;
    logic [31:0] entry_sum;
    logic        slot_free;
    logic        accept;

    assign accept     = rel.valid && rel.ready;
    assign rel.ready  = (state_reg == S_IDLE);
    assign slot_free  = !out_valid_reg || patch.ready;
    assign store_full = (count_reg >= CNT_W'(PENDING_DEPTH));

    assign patch.valid         = out_valid_reg;
    assign patch.patch_address = out_reg.addr;
    assign patch.patch_value   = out_reg.value;
    assign patch.patch_wide    = out_reg.wide;
    assign patch.write_enable  = out_reg.we;
    assign patch.status        = out_reg.status;
    assign patch.last          = out_reg.last;

    mrp_patch u_patch (
        .rel_kind          (kind_reg),
        .explicit_addend   (rela_reg),
        .symbol_unresolved (unres_reg),
        .symbol_weak       (weak_reg),
        .site_address      (site_reg),
        .site_word         (word_reg),
        .value             (v_reg),
        .store_full        (store_full),
        .res               (item_res),
        .push              (item_push),
        .drain             (item_drain),
        .lo_round_sum      (lo_round_sum),
        .lo_word           (lo_word)
    );

    assign wr_entry = '{addr: site_reg, word: word_reg, value: v_reg};
    assign rd_entry = pend_entry_t'(rd_bits);

    // The read port always follows the drain index; the entry is read out in the cycle after.
    mrp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PENDING_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_bits)
    );

    // carry-corrected HI16: ((hw << 16) + lo + V + 0x8000) >> 16
    assign entry_sum = {rd_entry.word[15:0], 16'd0} + lo_round_sum;

    // capture the item, form the effective value and register the next result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= rel.rel_kind;
            rela_reg   <= rel.explicit_addend;
            sym_reg    <= rel.symbol_value;
            addend_reg <= rel.addend;
            unres_reg  <= rel.symbol_unresolved;
            weak_reg   <= rel.symbol_weak;
            site_reg   <= rel.site_address;
            word_reg   <= rel.site_word;
        end
        if (state_reg == S_VALUE)
        begin
            v_reg <= rela_reg ? sym_reg + addend_reg : sym_reg;
        end
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !patch.ready;
        ram_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_VALUE;
                end
            end
            S_VALUE:
            begin
                state_next = S_PATCH;
            end
            S_PATCH:
            begin
                if (item_drain)
                begin
                    if (count_reg == '0)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(count_reg - 1'b1);
                        state_next = S_READ;
                    end
                end
                else if (slot_free)
                begin
                    out_next       = item_res;
                    out_valid_next = 1'b1;
                    if (item_push)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_ENTRY;
            end
            S_ENTRY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (rd_entry.value != v_reg)
                    begin
                        // drop the rest of the store and the LO16 itself
                        out_next.status = ST_MISMATCH;
                        out_next.last   = 1'b1;
                        count_next      = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        out_next.we    = 1'b1;
                        out_next.addr  = rd_entry.addr;
                        out_next.value = {32'd0, rd_entry.word[31:16], entry_sum[31:16]};
                        if (idx_reg == '0)
                        begin
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            idx_next   = idx_reg - 1'b1;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_FINAL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.we    = 1'b1;
                    out_next.addr  = site_reg;
                    out_next.value = {32'd0, lo_word};
                    out_next.last  = 1'b1;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // the pending count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PENDING_DEPTH))
        else $error("pending count beyond store depth");

    // a result that is not the last of its item is always a drained HI16 write
    a_mid_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        (patch.valid && !patch.last) |-> (patch.write_enable && patch.status == ST_OK))
        else $error("non-final result without a write");

    // draining only runs over live entries
    a_drain_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENTRY || state_reg == S_READ) |->
            (count_reg != '0 && CNT_W'(idx_reg) < count_reg))
        else $error("drain index outside live entries");

endmodule

// ===== bench/reloc_patch_check.sv =====
`timescale 1ns / 1ps

// Watch both channels, predict the patch beats of every relocation taken and
// compare them in order with the beats that come out.
module reloc_patch_check
    import mrp_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    mrp_in_if    rel,
    mrp_out_if   patch,
    output int   mismatches,
    output int   results_outstanding
);

    result_t     patch_expect_q[$];
    logic [63:0] hi_site  [DEPTH];
    logic [31:0] hi_word  [DEPTH];
    logic [63:0] hi_value [DEPTH];
    int          hi_count = 0;

    initial mismatches = 0;
    initial results_outstanding = 0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("%0t patch mismatch on %s: got %h, expected %h",
                 $realtime, what, got, want);
    endtask

    task automatic add_patch(input logic [63:0] addr, input logic [63:0] value,
                             input logic wide, input logic we,
                             input logic [2:0] status, input logic last);
        result_t b;
        b.addr   = we ? addr : '0;
        b.value  = we ? value : '0;
        b.wide   = wide;
        b.we     = we;
        b.status = status;
        b.last   = last;
        patch_expect_q.push_back(b);
    endtask

    // Work out the beats that the relocation now on the input channel causes.
    task automatic predict_patches();
        logic [63:0] v;
        logic [63:0] site;
        logic [31:0] w;
        logic [63:0] lo;
        logic [63:0] carried;
        logic [63:0] rounded;
        logic [25:0] field;
        logic [63:0] next_pc;
        int          i;

        site = rel.site_address;
        w    = rel.site_word;
        v    = rel.explicit_addend ? rel.symbol_value + $unsigned(rel.addend)
                                   : rel.symbol_value;

        if (rel.symbol_unresolved) begin
            add_patch('0, '0, 1'b0, 1'b0,
                      rel.symbol_weak ? ST_WEAK_SKIP : ST_UNKNOWN, 1'b1);
            return;
        end

        case (rel.rel_kind)
            KIND_NONE: add_patch('0, '0, 1'b0, 1'b0, ST_OK, 1'b1);
            KIND_WORD32: begin
                add_patch(site, {32'b0, rel.explicit_addend ? v[31:0] : w + v[31:0]},
                          1'b0, 1'b1, ST_OK, 1'b1);
            end
            KIND_JUMP26: begin
                next_pc = site + 64'd4;
                if (v[1:0] != 2'b00)
                    add_patch('0, '0, 1'b0, 1'b0, ST_MISALIGNED, 1'b1);
                else if (v[31:28] != next_pc[31:28])
                    add_patch('0, '0, 1'b0, 1'b0, ST_OVERFLOW, 1'b1);
                else begin
                    field = rel.explicit_addend ? v[27:2] : w[25:0] + v[27:2];
                    add_patch(site, {32'b0, w[31:26], field}, 1'b0, 1'b1, ST_OK, 1'b1);
                end
            end
            KIND_HI16: begin
                if (rel.explicit_addend) begin
                    rounded = v + HI16_ROUND;
                    add_patch(site, {32'b0, w[31:16], rounded[31:16]},
                              1'b0, 1'b1, ST_OK, 1'b1);
                end else if (hi_count >= DEPTH) begin
                    add_patch('0, '0, 1'b0, 1'b0, ST_STORE_FULL, 1'b1);
                end else begin
                    hi_site[hi_count]  = site;
                    hi_word[hi_count]  = w;
                    hi_value[hi_count] = v;
                    hi_count++;
                    add_patch('0, '0, 1'b0, 1'b0, ST_OK, 1'b1);
                end
            end
            KIND_LO16: begin
                if (rel.explicit_addend) begin
                    add_patch(site, {32'b0, w[31:16], v[15:0]}, 1'b0, 1'b1, ST_OK, 1'b1);
                    return;
                end
                lo = {{48{w[15]}}, w[15:0]};
                // Newest HI16 first; a value mismatch ends the item and empties
                // the store.
                for (i = hi_count - 1; i >= 0; i--) begin
                    if (hi_value[i] != v) begin
                        hi_count = 0;
                        add_patch('0, '0, 1'b0, 1'b0, ST_MISMATCH, 1'b1);
                        return;
                    end
                    carried = {32'b0, hi_word[i][15:0], 16'b0} + lo + v
                              + 64'(LO_ROUND);
                    add_patch(hi_site[i], {32'b0, hi_word[i][31:16], carried[31:16]},
                              1'b0, 1'b1, ST_OK, 1'b0);
                end
                hi_count = 0;
                carried = v + lo;
                add_patch(site, {32'b0, w[31:16], carried[15:0]}, 1'b0, 1'b1, ST_OK, 1'b1);
            end
            KIND_WORD64: begin
                if (rel.explicit_addend)
                    add_patch(site, v, 1'b1, 1'b1, ST_OK, 1'b1);
                else
                    add_patch('0, '0, 1'b0, 1'b0, ST_UNSUPPORTED, 1'b1);
            end
            KIND_HIGHER: begin
                rounded = v + HIGHER_ROUND;
                if (rel.explicit_addend)
                    add_patch(site, {32'b0, w[31:16], rounded[47:32]},
                              1'b0, 1'b1, ST_OK, 1'b1);
                else
                    add_patch('0, '0, 1'b0, 1'b0, ST_UNSUPPORTED, 1'b1);
            end
            default: begin
                rounded = v + HIGHEST_ROUND;
                if (rel.explicit_addend)
                    add_patch(site, {32'b0, w[31:16], rounded[63:48]},
                              1'b0, 1'b1, ST_OK, 1'b1);
                else
                    add_patch('0, '0, 1'b0, 1'b0, ST_UNSUPPORTED, 1'b1);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            patch_expect_q.delete();
            hi_count = 0;
        end else begin
            if (patch.valid && patch.ready) begin
                if (patch_expect_q.size() == 0) begin
                    flag_mismatch("unexpected beat, address", patch.patch_address, '0);
                end else begin
                    want = patch_expect_q.pop_front();
                    if (patch.patch_address !== want.addr)
                        flag_mismatch("patch_address", patch.patch_address, want.addr);
                    if (patch.patch_value !== want.value)
                        flag_mismatch("patch_value", patch.patch_value, want.value);
                    if (patch.patch_wide !== want.wide)
                        flag_mismatch("patch_wide", 64'(patch.patch_wide), 64'(want.wide));
                    if (patch.write_enable !== want.we)
                        flag_mismatch("write_enable", 64'(patch.write_enable), 64'(want.we));
                    if (patch.status !== want.status)
                        flag_mismatch("status", 64'(patch.status), 64'(want.status));
                    if (patch.last !== want.last)
                        flag_mismatch("last", 64'(patch.last), 64'(want.last));
                end
            end
            if (rel.valid && rel.ready)
                predict_patches();
        end
        results_outstanding = patch_expect_q.size();
    end

endmodule

// ===== bench/tb_mips_relocation_patcher.sv =====
`timescale 1ns / 1ps

// Top of the relocation patcher bench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts and compares every
// patch beat and hands back its mismatch count.
module tb_mips_relocation_patcher
    import mrp_pkg::*;
();

    localparam int PENDING_DEPTH = 16;
    localparam int RANDOM_RELOCS = 400;
    // Long receiver hold-off: far more than the block can buffer, so the
    // relocation channel must stall behind it.
    localparam int HOLD_CYCLES   = 300;
    // Cycles with no beat on either channel before the run is declared hung.
    // The slowest honest stretch is the hold-off above plus a full HI16 drain.
    localparam int STALL_LIMIT   = 5000;
    // Settling time after the last expected beat, to catch stray extra beats.
    localparam int TAIL_CYCLES   = 40;

    typedef struct packed {
        logic [2:0]  kind;
        logic        rela;
        logic [63:0] sym;
        logic [63:0] addend;
        logic        unres;
        logic        weak_bind;
        logic [63:0] site;
        logic [31:0] word;
    } reloc_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatches;
    int results_outstanding;
    int relocs_sent  = 0;
    int idle_cycles  = 0;
    bit steady       = 1'b0;   // no gaps on either side while set
    bit hold_patch   = 1'b0;   // request a long hold-off on the patch side

    mrp_in_if  rel_ch ();
    mrp_out_if patch_ch ();

    mips_relocation_patcher #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rel   (rel_ch),
        .patch (patch_ch)
    );

    reloc_patch_check #(
        .DEPTH (PENDING_DEPTH)
    ) check_u (
        .clk                 (clk),
        .rst_n               (rst_n),
        .rel                 (rel_ch),
        .patch               (patch_ch),
        .mismatches          (mismatches),
        .results_outstanding (results_outstanding)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly back-to-back, often a short gap, now and then a long one.
    function automatic int pause_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic reloc_t mk_reloc(logic [2:0] kind, logic rela, logic [63:0] sym,
                                        logic [63:0] addend, logic unres, logic weak_bind,
                                        logic [63:0] site, logic [31:0] word);
        reloc_t r;
        r.kind      = kind;
        r.rela      = rela;
        r.sym       = sym;
        r.addend    = addend;
        r.unres     = unres;
        r.weak_bind = weak_bind;
        r.site      = site;
        r.word      = word;
        return r;
    endfunction

    // Anything at all the fields allow.
    function automatic reloc_t any_reloc();
        return mk_reloc(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), rand64(),
                        rand64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        rand64(), $urandom);
    endfunction

    // A resolved relocation whose effective value is v. Jumps are mostly
    // steered into an aligned target inside the 256 MB region of site + 4 so
    // that they actually patch.
    function automatic reloc_t aimed_reloc(logic [2:0] kind, logic rela, logic [63:0] v);
        reloc_t      r;
        logic [63:0] next_pc;
        r = mk_reloc(kind, rela, '0, rand64(), 1'b0, 1'($urandom_range(0, 1)),
                     rand64(), $urandom);
        if (kind == KIND_JUMP26 && $urandom_range(0, 3) != 0) begin
            next_pc = r.site + 64'd4;
            v = {v[63:32], next_pc[31:28], v[27:2], 2'b00};
        end
        r.sym = rela ? v - r.addend : v;
        return r;
    endfunction

    // Idle for the given number of cycles, then offer one relocation and hold
    // it until the block takes it. Returns on the falling edge after the beat.
    task automatic offer_reloc(input reloc_t r, input int gap);
        if (gap > 0) begin
            rel_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rel_ch.valid             <= 1'b1;
        rel_ch.rel_kind          <= r.kind;
        rel_ch.explicit_addend   <= r.rela;
        rel_ch.symbol_value      <= r.sym;
        rel_ch.addend            <= r.addend;
        rel_ch.symbol_unresolved <= r.unres;
        rel_ch.symbol_weak       <= r.weak_bind;
        rel_ch.site_address      <= r.site;
        rel_ch.site_word         <= r.word;
        @(posedge clk);
        while (!rel_ch.ready)
            @(posedge clk);
        @(negedge clk);
        relocs_sent++;
    endtask

    // Drop valid and hold off until every predicted beat has come out.
    task automatic drain_patches();
        rel_ch.valid <= 1'b0;
        wait (results_outstanding == 0);
        @(negedge clk);
    endtask

    // Patch side: random bursts of ready with gaps, or one long hold-off when
    // the stimulus asks for it. The hold-off length is counted here.
    initial begin
        int burst;
        int gap;
        patch_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_patch) begin
                patch_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_patch = 1'b0;
            end else begin
                burst = $urandom_range(1, 12);
                patch_ch.ready <= 1'b1;
                repeat (burst) @(negedge clk);
                gap = pause_len();
                if (gap > 0) begin
                    patch_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    end

    // Watchdog: any beat on either channel counts as progress.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((rel_ch.valid && rel_ch.ready) || (patch_ch.valid && patch_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        reloc_t      r;
        logic [63:0] v;
        int          n;
        int          pick;
        int          base;
        int          done;
        bit          first_group;
        bit          clean;
        bit          mid_drain_done;
        bit          second_hold_done;

        // Every block input known from time zero.
        rel_ch.valid             = 1'b0;
        rel_ch.rel_kind          = KIND_NONE;
        rel_ch.explicit_addend   = 1'b0;
        rel_ch.symbol_value      = '0;
        rel_ch.addend            = '0;
        rel_ch.symbol_unresolved = 1'b0;
        rel_ch.symbol_weak       = 1'b0;
        rel_ch.site_address      = '0;
        rel_ch.site_word         = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- Directed: one of each kind, the status cases, field extremes.
        offer_reloc(mk_reloc(KIND_NONE, 1'b0, '0, '0, 1'b0, 1'b0, '0, '0), 0);
        // Unresolved weak symbol: skipped with no write.
        offer_reloc(mk_reloc(KIND_WORD32, 1'b1, '1, '1, 1'b1, 1'b1, '1, '1), 0);
        // Unresolved strong symbol: unknown-symbol status.
        offer_reloc(mk_reloc(KIND_JUMP26, 1'b0, 64'h0040_0000, '0, 1'b1, 1'b0,
                             64'h0040_0000, 32'h0800_0000), pause_len());
        // Word32 REL, wrap of the 32-bit sum.
        offer_reloc(mk_reloc(KIND_WORD32, 1'b0, '1, '0, 1'b0, 1'b0, '1, '1), 0);
        // Word32 RELA with a negative addend.
        offer_reloc(mk_reloc(KIND_WORD32, 1'b1, 64'h1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0,
                             1'b1, 64'h8000_0000_0000_0000, 32'h1234_5678), 0);
        // Misaligned jump target.
        offer_reloc(mk_reloc(KIND_JUMP26, 1'b1, 64'h0040_0000, 64'h2, 1'b0, 1'b0,
                             64'h0040_0000, 32'h0C00_0000), pause_len());
        // Jump target outside the site's region.
        offer_reloc(mk_reloc(KIND_JUMP26, 1'b0, 64'h1000_0000, '0, 1'b0, 1'b0,
                             64'h100, 32'h0C00_0000), 0);
        // REL jump whose 26-bit field wraps; upper symbol bits are ignored.
        offer_reloc(mk_reloc(KIND_JUMP26, 1'b0, 64'h8000_0000_0FFF_FFFC, '0, 1'b0, 1'b0,
                             64'h0000_0000_0FFF_FFF8, 32'h0FFF_FFFF), 0);
        // RELA jump where site + 4 crosses into the next region.
        offer_reloc(mk_reloc(KIND_JUMP26, 1'b1, 64'h1000_0000, 64'h0FFF_FFFC, 1'b0,
                             1'b0, 64'h0FFF_FFFC, 32'hFC00_0000), pause_len());
        // RELA HI16 with rounding that wraps the top.
        offer_reloc(mk_reloc(KIND_HI16, 1'b1, 64'hFFFF_FFFF_FFFF_8000, '0, 1'b0, 1'b0,
                             64'h1000, 32'h3C01_FFFF), 0);
        // RELA LO16 with the most negative addend.
        offer_reloc(mk_reloc(KIND_LO16, 1'b1, 64'h1234_5678_9ABC_DEF0,
                             64'h8000_0000_0000_0000, 1'b0, 1'b1, 64'h1004,
                             32'h2421_0000), 0);
        offer_reloc(mk_reloc(KIND_WORD64, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF,
                             64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'h2000, '0), 0);
        offer_reloc(mk_reloc(KIND_HIGHER, 1'b1, 64'h0000_7FFF_7FFF_8000, '0, 1'b0,
                             1'b0, 64'h2008, 32'h3C01_0000), pause_len());
        offer_reloc(mk_reloc(KIND_HIGHEST, 1'b1, 64'hFFFF_7FFF_7FFF_8000, '0, 1'b0,
                             1'b0, 64'h2010, 32'h3C01_FFFF), 0);
        // REL forms that have no handler.
        offer_reloc(mk_reloc(KIND_WORD64, 1'b0, rand64(), rand64(), 1'b0, 1'b0,
                             rand64(), $urandom), 0);
        offer_reloc(mk_reloc(KIND_HIGHER, 1'b0, rand64(), rand64(), 1'b0, 1'b1,
                             rand64(), $urandom), 0);
        offer_reloc(mk_reloc(KIND_HIGHEST, 1'b0, rand64(), rand64(), 1'b0, 1'b0,
                             rand64(), $urandom), pause_len());
        // Two REL HI16 paired by a LO16 with a negative low half.
        offer_reloc(mk_reloc(KIND_HI16, 1'b0, 64'h1234_8000, '0, 1'b0, 1'b0,
                             64'h3000, 32'h3C04_0012), 0);
        offer_reloc(mk_reloc(KIND_HI16, 1'b0, 64'h1234_8000, '0, 1'b0, 1'b0,
                             64'h3008, 32'h3C05_FFFF), 0);
        offer_reloc(mk_reloc(KIND_LO16, 1'b0, 64'h1234_8000, '0, 1'b0, 1'b0,
                             64'h300C, 32'h2484_8000), 0);
        // REL LO16 with nothing stored.
        offer_reloc(mk_reloc(KIND_LO16, 1'b0, '1, '0, 1'b0, 1'b0, 64'h3010,
                             32'h8C82_7FFF), 0);
        // HI16 values disagree: newest patches, then the mismatch status.
        offer_reloc(mk_reloc(KIND_HI16, 1'b0, 64'h4000, '0, 1'b0, 1'b0,
                             64'h4000, 32'h3C06_0001), 0);
        offer_reloc(mk_reloc(KIND_HI16, 1'b0, 64'h5000, '0, 1'b0, 1'b0,
                             64'h4004, 32'h3C07_0002), 0);
        offer_reloc(mk_reloc(KIND_LO16, 1'b0, 64'h5000, '0, 1'b0, 1'b0,
                             64'h4008, 32'h24E7_0010), 0);
        // Store was cleared by the mismatch: this LO16 patches only itself.
        offer_reloc(mk_reloc(KIND_LO16, 1'b0, 64'h4000, '0, 1'b0, 1'b0,
                             64'h400C, 32'h24C6_0020), 0);

        // Sender pause: let every predicted beat out before going random.
        drain_patches();

        // ---- Random: mostly HI16 runs closed by a LO16, plus singles and noise.
        base             = relocs_sent;
        first_group      = 1'b1;
        mid_drain_done   = 1'b0;
        second_hold_done = 1'b0;
        done             = 0;
        while (done < RANDOM_RELOCS) begin
            steady = (done >= 320 && done < 370);
            if (!mid_drain_done && done >= 180) begin
                mid_drain_done = 1'b1;
                drain_patches();
            end
            if (!second_hold_done && done >= 260) begin
                second_hold_done = 1'b1;
                hold_patch = 1'b1;
            end

            pick = first_group ? 0 : $urandom_range(0, 99);
            if (pick < 45) begin
                // The first run overfills the store under a long patch hold-off,
                // then drains the full store in one LO16.
                clean = first_group;
                if (first_group) begin
                    n = PENDING_DEPTH + 1;
                    hold_patch = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(PENDING_DEPTH - 4, PENDING_DEPTH + 2);
                end else begin
                    n = $urandom_range(0, 4);
                end
                first_group = 1'b0;
                v = rand64();
                repeat (n) begin
                    if (!clean && $urandom_range(0, 9) == 0)
                        offer_reloc(any_reloc(), pause_len());
                    if (!clean && $urandom_range(0, 11) == 0)
                        r = aimed_reloc(KIND_HI16, 1'b0, rand64());
                    else
                        r = aimed_reloc(KIND_HI16, 1'b0, v);
                    offer_reloc(r, pause_len());
                end
                offer_reloc(aimed_reloc(KIND_LO16, 1'b0, v), pause_len());
            end else if (pick < 85) begin
                offer_reloc(aimed_reloc(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                        rand64()), pause_len());
            end else begin
                offer_reloc(any_reloc(), pause_len());
            end
            done = relocs_sent - base;
        end
        steady = 1'b0;

        // ---- Wind down: wait for the last predicted beat, then settle.
        rel_ch.valid <= 1'b0;
        wait (results_outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== mips_relocation_patcher.f =====
src/mrp_pkg.sv
src/mrp_in_if.sv
src/mrp_out_if.sv
src/mrp_ram.sv
src/mrp_patch.sv
src/mips_relocation_patcher.sv
bench/reloc_patch_check.sv
bench/tb_mips_relocation_patcher.sv
